### rtl/ffo_pkg.sv
// Shared constants, types and helpers for the flow frame odometry block.
`default_nettype none

package ffo_pkg;

  // Frame markers
  localparam logic [7:0] HDR_BYTE   = 8'hFE;
  localparam logic [7:0] COUNT_BYTE = 8'h0A;
  localparam logic [7:0] TAIL_BYTE  = 8'h55;
  localparam logic [7:0] VALID_BYTE = 8'hF5;
  localparam logic [15:0] DIST_BAD  = 16'hFFFF;
  localparam int unsigned FRAME_LEN = 13;

  // pi/4 in Q30
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

  // Serial arithmetic widths
  localparam int unsigned MUL_W = 32;
  localparam int unsigned DIV_W = 32;
  localparam int unsigned DVS_W = 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIXED_HEIGHT = 3'd0,
    CFG_CONF_FLOOR   = 3'd1,
    CFG_NEG_X        = 3'd2,
    CFG_NEG_Y        = 3'd3,
    CFG_MOUNT        = 3'd4,
    CFG_START_YAW    = 3'd5
  } cfg_idx_e;

  // Handshake between the sequencer and a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Series divisor n*(n+1) for term k of the sine (odd) or cosine series
  function automatic logic [DVS_W-1:0] series_div(input logic odd, input logic [2:0] k);
    logic [DVS_W-1:0] d;
    case ({odd, k})
      4'b1_000: d = 8'd6;
      4'b1_001: d = 8'd20;
      4'b1_010: d = 8'd42;
      4'b1_011: d = 8'd72;
      4'b1_100: d = 8'd110;
      4'b1_101: d = 8'd156;
      4'b0_000: d = 8'd2;
      4'b0_001: d = 8'd12;
      4'b0_010: d = 8'd30;
      4'b0_011: d = 8'd56;
      4'b0_100: d = 8'd90;
      4'b0_101: d = 8'd132;
      default:  d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/ffo_smul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
`default_nettype none

module ffo_smul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ffo_pkg::MUL_W-1:0]    a_i,
  input  wire logic [ffo_pkg::MUL_W-1:0]    b_i,
  output ffo_pkg::unit_sts_t                sts_o,
  output logic      [2*ffo_pkg::MUL_W-1:0]  p_o
);

  localparam int unsigned W  = ffo_pkg::MUL_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [2*W-1:0] p_q, p_d;
  logic [W:0]    sum;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    p_d    = p_q;
    sum    = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : '0);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      p_d    = {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_d   = {sum, p_q[W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign p_o        = p_q;

endmodule

`default_nettype wire

### rtl/ffo_sdiv.sv
// Restoring divider by a narrow divisor, one quotient bit per cycle.
`default_nettype none

module ffo_sdiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ffo_pkg::DIV_W-1:0]   num_i,
  input  wire logic [ffo_pkg::DVS_W-1:0]   den_i,
  output ffo_pkg::unit_sts_t               sts_o,
  output logic      [ffo_pkg::DIV_W-1:0]   quo_o
);

  localparam int unsigned W  = ffo_pkg::DIV_W;
  localparam int unsigned DW = ffo_pkg::DVS_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, q_q[W-1]};
    fits   = trial >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      q_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      q_d   = {q_q[W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = q_q;

endmodule

`default_nettype wire

### rtl/flow_frame_odometry.sv
// Top level: flow sensor frame parser, serial trigonometry and map integrator.
`default_nettype none

// Takes serial bytes and pose corrections as words on the slave stream
// (tuser 0 = byte, 1 = pose correction). Bytes are framed as header 0xFE plus
// 13 bytes; a frame passes when count, tail, XOR and validity bytes match and a
// height is available (fixed_height register, or the laser distance if it is
// neither 0 nor 0xFFFF and its confidence is at least conf_floor). A passing
// frame's flow times height is rotated by yaw plus mount angle and added to
// the wrapping map accumulators; one result word follows. Input words are
// accepted only while the block is idle. After a frame's last byte the input
// stays closed for the frame check and, if the frame passes, for twenty
// products through one bit-serial 32x32 multiplier (angle, square, twelve
// series terms, two flow products, four rotation products), twelve series
// divides through a bit-serial divider, each after its series product, and
// the load of the output register. A result waits in the output register
// without stopping further input bytes; the sequencer holds only when a
// second result arrives before the first is taken.

module flow_frame_odometry #(
  parameter int unsigned POS_BITS  = 48,
  parameter int unsigned TRIG_BITS = 15
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: byte_in[7:0], fix_x[55:8], fix_y[103:56], fix_yaw[119:104]
  input  wire logic [119:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic         s_axis_tuser,
  // master stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: map_x_out[47:0], map_y_out[95:48], ground_height[111:96],
  //        reported_yaw[127:112], raw_flow_x_out[143:128], raw_flow_y_out[159:144]
  output logic      [159:0] m_axis_tdata,
  // configuration
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  localparam int unsigned MW  = ffo_pkg::MUL_W;
  localparam int unsigned DW  = ffo_pkg::DIV_W;
  localparam int unsigned RSH = 30 - TRIG_BITS;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_ANGLE  = 9'b000000100,
    ST_SQUARE = 9'b000001000,
    ST_TMUL   = 9'b000010000,
    ST_TDIV   = 9'b000100000,
    ST_FLOW   = 9'b001000000,
    ST_PROD   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  // configuration registers
  logic [15:0] fixed_height_q;
  logic [7:0]  conf_floor_q;
  logic        neg_x_q, neg_y_q;
  logic [15:0] mount_q;

  // control
  state_e      state_q, state_d;
  logic [3:0]  phase_q, phase_d;
  logic        run_q, run_d;
  logic        odd_q, odd_d;
  logic [2:0]  k_q, k_d;
  logic [1:0]  idx_q, idx_d;
  logic        m_valid_q, m_valid_d;

  // working data
  logic [7:0]  bytes_q [ffo_pkg::FRAME_LEN];
  logic [POS_BITS-1:0] map_x_q, map_x_d, map_y_q, map_y_d;
  logic [15:0] yaw_q, yaw_d;
  logic [15:0] h_q, h_d;
  logic [1:0]  quad_q, quad_d;
  logic        swap_q, swap_d;
  logic [29:0] x_q, x_d, x2_q, x2_d;
  logic [30:0] term_q, term_d;
  logic signed [33:0] sum_q, sum_d;
  logic [TRIG_BITS-1:0] ser_odd_q, ser_odd_d, ser_even_q, ser_even_d;
  logic [31:0] dxs_q, dxs_d, dys_q, dys_d;
  logic signed [63:0] accx_q, accx_d, accy_q, accy_d;
  logic [159:0] out_q, out_d;

  // serial units
  logic        mul_start, div_start;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic [DW-1:0] div_quo;
  ffo_pkg::unit_sts_t mul_sts, div_sts;

  ffo_smul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .sts_o  (mul_sts),
    .p_o    (mul_p)
  );

  ffo_sdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mul_p[61:30]),
    .den_i  (ffo_pkg::series_div(odd_q, k_q)),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  // input fields
  logic        in_acc;
  logic [7:0]  byte_in;
  logic [47:0] fix_x, fix_y;
  logic [15:0] fix_yaw;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign byte_in = s_axis_tdata[7:0];
  assign fix_x   = s_axis_tdata[55:8];
  assign fix_y   = s_axis_tdata[103:56];
  assign fix_yaw = s_axis_tdata[119:104];

  // frame checks
  logic [7:0]  xsum;
  logic [15:0] laser_dist, flx, fly;
  logic        frame_ok, dist_ok;
  always_comb begin
    xsum = '0;
    for (int i = 1; i <= 10; i++) xsum ^= bytes_q[i];
  end
  assign flx  = {bytes_q[2], bytes_q[1]};
  assign fly  = {bytes_q[4], bytes_q[3]};
  assign laser_dist = {bytes_q[8], bytes_q[7]};
  assign frame_ok = (bytes_q[0] == ffo_pkg::COUNT_BYTE) && (bytes_q[12] == ffo_pkg::TAIL_BYTE)
                 && (xsum == bytes_q[11]) && (bytes_q[9] == ffo_pkg::VALID_BYTE);
  assign dist_ok  = (laser_dist != '0) && (laser_dist != ffo_pkg::DIST_BAD)
                 && (bytes_q[10] >= conf_floor_q);

  // angle folding
  logic [15:0] ang;
  logic [13:0] ang_r, ang_f;
  assign ang   = yaw_q + mount_q;
  assign ang_r = ang[13:0];
  assign ang_f = (ang_r <= 14'd8192) ? ang_r : 14'(15'd16384 - {1'b0, ang_r});

  // flow magnitudes and signs (negation applied to the sign only)
  logic [16:0] flx_mag, fly_mag;
  logic        dx_neg, dy_neg;
  assign flx_mag = flx[15] ? 17'(-{flx[15], flx}) : {1'b0, flx};
  assign fly_mag = fly[15] ? 17'(-{fly[15], fly}) : {1'b0, fly};
  assign dx_neg  = flx[15] ^ neg_x_q;
  assign dy_neg  = fly[15] ^ neg_y_q;

  // sine/cosine from octant results and quadrant
  logic [TRIG_BITS-1:0] s0, c0, s_mag, c_mag;
  logic                 s_neg, c_neg;
  always_comb begin
    s0 = swap_q ? ser_even_q : ser_odd_q;
    c0 = swap_q ? ser_odd_q  : ser_even_q;
    case (quad_q)
      2'd0:    begin s_mag = s0; s_neg = 1'b0; c_mag = c0; c_neg = 1'b0; end
      2'd1:    begin s_mag = c0; s_neg = 1'b0; c_mag = s0; c_neg = 1'b1; end
      2'd2:    begin s_mag = s0; s_neg = 1'b1; c_mag = c0; c_neg = 1'b1; end
      default: begin s_mag = c0; s_neg = 1'b1; c_mag = s0; c_neg = 1'b0; end
    endcase
  end

  // rotation product select: (dxs,s) (dys,c) (dys,s) (dxs,c)
  logic        prod_neg;
  logic signed [63:0] prod_s;
  always_comb begin
    case (idx_q)
      2'd0:    prod_neg = dx_neg ^ s_neg;
      2'd1:    prod_neg = dy_neg ^ c_neg;
      2'd2:    prod_neg = dy_neg ^ s_neg;
      default: prod_neg = dx_neg ^ c_neg;
    endcase
    prod_s = prod_neg ? -signed'(mul_p) : signed'(mul_p);
  end

  // series rounding
  logic signed [33:0] sum_term, sum_cl;
  logic [33:0]        sum_rnd;
  logic [TRIG_BITS-1:0] ser_res;
  assign sum_term = k_q[0] ? sum_q + signed'({3'b0, div_quo[30:0]})
                           : sum_q - signed'({3'b0, div_quo[30:0]});
  assign sum_cl   = sum_term[33] ? '0 : sum_term;
  assign sum_rnd  = (unsigned'(sum_cl) + (34'd1 << (RSH - 1))) >> RSH;
  assign ser_res  = (|sum_rnd[33:TRIG_BITS]) ? '1 : sum_rnd[TRIG_BITS-1:0];

  // final shift and output formatting
  logic signed [63:0] dxm, dym, ext_x, ext_y;
  logic               out_free;
  assign dxm = (accx_q + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
  assign dym = (accy_q + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
  assign out_free = !m_valid_q || m_axis_tready;

  logic signed [63:0] fx_ext, fy_ext;
  assign fx_ext = 64'(signed'(fix_x));
  assign fy_ext = 64'(signed'(fix_y));

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    run_d      = run_q;
    odd_d      = odd_q;
    k_d        = k_q;
    idx_d      = idx_q;
    m_valid_d  = m_valid_q;
    map_x_d    = map_x_q;
    map_y_d    = map_y_q;
    yaw_d      = yaw_q;
    h_d        = h_q;
    quad_d     = quad_q;
    swap_d     = swap_q;
    x_d        = x_q;
    x2_d       = x2_q;
    term_d     = term_q;
    sum_d      = sum_q;
    ser_odd_d  = ser_odd_q;
    ser_even_d = ser_even_q;
    dxs_d      = dxs_q;
    dys_d      = dys_q;
    accx_d     = accx_q;
    accy_d     = accy_q;
    out_d      = out_q;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    ext_x      = 64'(signed'(map_x_q));
    ext_y      = 64'(signed'(map_y_q));

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            map_x_d = fx_ext[POS_BITS-1:0];
            map_y_d = fy_ext[POS_BITS-1:0];
            yaw_d   = fix_yaw;
          end else if (phase_q == '0) begin
            phase_d = (byte_in == ffo_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
          end else if (phase_q == 4'(ffo_pkg::FRAME_LEN)) begin
            phase_d = '0;
            state_d = ST_CHECK;
          end else begin
            phase_d = phase_q + 4'd1;
          end
        end
      end
      ST_CHECK: begin
        quad_d = ang[15:14];
        swap_d = (ang_r > 14'd8192);
        h_d    = (fixed_height_q != '0) ? fixed_height_q : laser_dist;
        if (frame_ok && ((fixed_height_q != '0) || dist_ok)) state_d = ST_ANGLE;
        else state_d = ST_IDLE;
      end
      ST_ANGLE: begin
        mul_a = MW'(ang_f);
        mul_b = MW'(ffo_pkg::QUARTER_PI_Q30);
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_sts.done) begin
          run_d   = 1'b0;
          x_d     = mul_p[42:13];
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_a = MW'(x_q);
        mul_b = MW'(x_q);
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_sts.done) begin
          run_d   = 1'b0;
          x2_d    = mul_p[59:30];
          odd_d   = 1'b1;
          k_d     = '0;
          term_d  = {1'b0, x_q};
          sum_d   = 34'(signed'({4'b0, x_q}));
          state_d = ST_TMUL;
        end
      end
      ST_TMUL: begin
        mul_a = MW'(term_q);
        mul_b = MW'(x2_q);
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_sts.done) begin
          run_d     = 1'b0;
          div_start = 1'b1;
          state_d   = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_sts.done) begin
          term_d = div_quo[30:0];
          sum_d  = sum_term;
          if (k_q == 3'd5) begin
            k_d = '0;
            if (odd_q) begin
              ser_odd_d = ser_res;
              odd_d     = 1'b0;
              term_d    = 31'd1 << 30;
              sum_d     = 34'sd1 <<< 30;
              state_d   = ST_TMUL;
            end else begin
              ser_even_d = ser_res;
              idx_d      = '0;
              state_d    = ST_FLOW;
            end
          end else begin
            k_d     = k_q + 3'd1;
            state_d = ST_TMUL;
          end
        end
      end
      ST_FLOW: begin
        mul_a = MW'(idx_q[0] ? fly_mag : flx_mag);
        mul_b = MW'(h_q);
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_sts.done) begin
          run_d = 1'b0;
          if (idx_q[0]) begin
            dys_d   = mul_p[31:0];
            idx_d   = '0;
            state_d = ST_PROD;
          end else begin
            dxs_d = mul_p[31:0];
            idx_d = 2'd1;
          end
        end
      end
      ST_PROD: begin
        mul_a = (idx_q == 2'd0 || idx_q == 2'd3) ? dxs_q : dys_q;
        mul_b = MW'(idx_q[0] ? c_mag : s_mag);
        if (!run_q) begin
          mul_start = 1'b1;
          run_d     = 1'b1;
        end else if (mul_sts.done) begin
          run_d = 1'b0;
          idx_d = idx_q + 2'd1;
          case (idx_q)
            2'd0:    accx_d = prod_s;
            2'd1:    accx_d = accx_q + prod_s;
            2'd2:    accy_d = prod_s;
            default: begin
              accy_d  = accy_q - prod_s;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          map_x_d   = map_x_q + dxm[POS_BITS-1:0];
          map_y_d   = map_y_q + dym[POS_BITS-1:0];
          ext_x     = 64'(signed'(map_x_d));
          ext_y     = 64'(signed'(map_y_d));
          out_d     = {fly, flx, yaw_q, h_q, ext_y[47:0], ext_x[47:0]};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // yaw preset from configuration (block idle by contract)
    if (cfg_we_i && cfg_idx_i == ffo_pkg::CFG_START_YAW) yaw_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= '0;
      run_q          <= 1'b0;
      odd_q          <= 1'b0;
      k_q            <= '0;
      idx_q          <= '0;
      m_valid_q      <= 1'b0;
      map_x_q        <= '0;
      map_y_q        <= '0;
      yaw_q          <= '0;
      fixed_height_q <= '0;
      conf_floor_q   <= 8'd10;
      neg_x_q        <= 1'b0;
      neg_y_q        <= 1'b0;
      mount_q        <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      run_q     <= run_d;
      odd_q     <= odd_d;
      k_q       <= k_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
      map_x_q   <= map_x_d;
      map_y_q   <= map_y_d;
      yaw_q     <= yaw_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ffo_pkg::CFG_FIXED_HEIGHT: fixed_height_q <= cfg_data_i;
          ffo_pkg::CFG_CONF_FLOOR:   conf_floor_q   <= cfg_data_i[7:0];
          ffo_pkg::CFG_NEG_X:        neg_x_q        <= cfg_data_i[0];
          ffo_pkg::CFG_NEG_Y:        neg_y_q        <= cfg_data_i[0];
          ffo_pkg::CFG_MOUNT:        mount_q        <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser && phase_q != '0) bytes_q[4'(phase_q - 4'd1)] <= byte_in;
    h_q        <= h_d;
    quad_q     <= quad_d;
    swap_q     <= swap_d;
    x_q        <= x_d;
    x2_q       <= x2_d;
    term_q     <= term_d;
    sum_q      <= sum_d;
    ser_odd_q  <= ser_odd_d;
    ser_even_q <= ser_even_d;
    dxs_q      <= dxs_d;
    dys_q      <= dys_d;
    accx_q     <= accx_d;
    accy_q     <= accy_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // multiplier and divider take turns
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= 4'(ffo_pkg::FRAME_LEN))
    else $error("frame phase out of range");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 3'd5)
    else $error("series term index out of range");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished frame did not reach the output register");

endmodule

`default_nettype wire

### dv/flow_frame_odometry_test.sv
// Stream testbench for the flow frame odometry block with its own predictor.
`timescale 1ns / 100ps

module flow_frame_odometry_test;

  localparam int unsigned TRIG_Q   = 15;
  // last frame byte starts the full computation; leave margin before idle moves
  localparam int unsigned SETTLE   = 1300;
  localparam int unsigned LONG_HOLD = 4000;
  // register index that maps to nothing; the block must ignore it
  localparam logic [2:0] CFG_UNUSED = 3'd6;

  typedef enum int { FLAW_NONE, FLAW_COUNT, FLAW_TAIL, FLAW_XOR, FLAW_FLAG } flaw_e;

  // one word on the input stream
  typedef struct {
    logic         pose;
    logic [119:0] data;
  } in_word_t;

  // one expected odometry result
  typedef struct {
    logic [47:0] map_x;
    logic [47:0] map_y;
    logic [15:0] height;
    logic [15:0] yaw;
    logic [15:0] flow_x;
    logic [15:0] flow_y;
  } odo_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: byte_in[7:0], fix_x[55:8], fix_y[103:56], fix_yaw[119:104]
  logic [119:0] s_axis_tdata = '0;
  // tuser: req_type
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: map_x_out[47:0], map_y_out[95:48], ground_height[111:96],
  //        reported_yaw[127:112], raw_flow_x_out[143:128], raw_flow_y_out[159:144]
  logic [159:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  flow_frame_odometry u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers, parser and integrator
  // ---------------------------------------------------------------------------
  logic [15:0] fixed_height_r;
  logic [7:0]  conf_floor_r;
  logic        neg_x_r, neg_y_r;
  logic [15:0] mount_r;
  int          parse_phase;
  logic [7:0]  frame_buf [ffo_pkg::FRAME_LEN];
  logic [47:0] acc_x, acc_y;
  logic [15:0] heading;

  in_word_t    pending_words [$];
  odo_result_t odo_expected [$];

  bit calm;          // no idling on either side
  bit failed;
  bit in_took;
  int in_gap, rx_gap, hold_left;
  bit hold_done;
  int words_sent, frames_sent, poses_sent, results_seen, cfg_writes;

  // Q30 Taylor series, rounded to TRIG_Q and capped
  function automatic longint trig_series_q(input longint unsigned x, input bit odd);
    longint unsigned x2, term, n;
    longint acc;
    x2 = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    n = odd ? 2 : 1;
    acc = longint'(term);
    for (int k = 0; k < 6; k++) begin
      term = ((term * x2) >> 30) / (n * (n + 1));
      n += 2;
      if (k & 1) acc += longint'(term);
      else acc -= longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + (64'sd1 << (29 - TRIG_Q))) >>> (30 - TRIG_Q);
    if (acc > (64'sd1 << TRIG_Q) - 1) acc = (64'sd1 << TRIG_Q) - 1;
    return acc;
  endfunction

  // quadrant/octant folded sine and cosine
  task automatic angle_sincos(input logic [15:0] ang, output longint s, output longint c);
    logic [1:0] quad;
    longint unsigned r, x;
    longint s0, c0;
    quad = ang[15:14];
    r = 64'(ang[13:0]);
    if (r <= 8192) begin
      x = (r * longint'(ffo_pkg::QUARTER_PI_Q30)) >> 13;
      s0 = trig_series_q(x, 1'b1);
      c0 = trig_series_q(x, 1'b0);
    end else begin
      x = ((16384 - r) * longint'(ffo_pkg::QUARTER_PI_Q30)) >> 13;
      s0 = trig_series_q(x, 1'b0);
      c0 = trig_series_q(x, 1'b1);
    end
    case (quad)
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  // checks a complete frame and integrates it; queues a result when one is due
  task automatic close_frame();
    logic [7:0]  chk;
    logic [15:0] fx, fy, laser_dist, h;
    longint flx, fly, dxs, dys, s, c, dxm, dym;
    odo_result_t res;
    chk = '0;
    for (int i = 1; i <= 10; i++) chk ^= frame_buf[i];
    if (frame_buf[0] != ffo_pkg::COUNT_BYTE || frame_buf[12] != ffo_pkg::TAIL_BYTE) return;
    if (chk != frame_buf[11] || frame_buf[9] != ffo_pkg::VALID_BYTE) return;
    fx = {frame_buf[2], frame_buf[1]};
    fy = {frame_buf[4], frame_buf[3]};
    laser_dist = {frame_buf[8], frame_buf[7]};
    if (fixed_height_r != 0) begin
      h = fixed_height_r;
    end else begin
      if (laser_dist == 16'd0 || laser_dist == ffo_pkg::DIST_BAD) return;
      if (frame_buf[10] < conf_floor_r) return;
      h = laser_dist;
    end
    flx = longint'($signed(fx));
    fly = longint'($signed(fy));
    dxs = (neg_x_r ? -flx : flx) * longint'(h);
    dys = (neg_y_r ? -fly : fly) * longint'(h);
    angle_sincos(heading + mount_r, s, c);
    // round half up: floor of (v + half)
    dxm = (dxs * s + dys * c + (64'sd1 << (TRIG_Q - 1))) >>> TRIG_Q;
    dym = (dys * s - dxs * c + (64'sd1 << (TRIG_Q - 1))) >>> TRIG_Q;
    acc_x = acc_x + dxm[47:0];
    acc_y = acc_y + dym[47:0];
    res.map_x = acc_x;
    res.map_y = acc_y;
    res.height = h;
    res.yaw = heading;
    res.flow_x = fx;
    res.flow_y = fy;
    odo_expected = {odo_expected, res};
  endtask

  task automatic advance_odometry(input logic pose, input logic [119:0] d);
    if (pose) begin
      acc_x = d[55:8];
      acc_y = d[103:56];
      heading = d[119:104];
      return;
    end
    if (parse_phase == 0) begin
      parse_phase = (d[7:0] == ffo_pkg::HDR_BYTE) ? 1 : 0;
      return;
    end
    frame_buf[parse_phase - 1] = d[7:0];
    if (parse_phase < int'(ffo_pkg::FRAME_LEN)) begin
      parse_phase++;
      return;
    end
    parse_phase = 0;
    close_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    in_word_t w;
    w.pose = 1'b0;
    w.data = 120'({$urandom(), $urandom(), $urandom(), $urandom()});
    w.data[7:0] = b;
    pending_words = {pending_words, w};
  endtask

  task automatic add_pose(input logic [47:0] x, input logic [47:0] y, input logic [15:0] yaw);
    in_word_t w;
    w.pose = 1'b1;
    w.data = {yaw, y, x, 8'($urandom())};
    pending_words = {pending_words, w};
    poses_sent++;
  endtask

  task automatic add_frame(input logic [15:0] fx, input logic [15:0] fy,
                           input logic [15:0] laser_dist, input logic [7:0] conf,
                           input flaw_e flaw);
    logic [7:0] b [ffo_pkg::FRAME_LEN];
    logic [7:0] chk;
    b[0] = ffo_pkg::COUNT_BYTE;
    {b[2], b[1]} = fx;
    {b[4], b[3]} = fy;
    b[5] = 8'($urandom());
    b[6] = 8'($urandom());
    {b[8], b[7]} = laser_dist;
    b[9] = ffo_pkg::VALID_BYTE;
    b[10] = conf;
    b[12] = ffo_pkg::TAIL_BYTE;
    if (flaw == FLAW_FLAG) b[9] = ffo_pkg::VALID_BYTE ^ 8'($urandom_range(1, 255));
    chk = '0;
    for (int i = 1; i <= 10; i++) chk ^= b[i];
    b[11] = chk;
    case (flaw)
      FLAW_COUNT: b[0] = ffo_pkg::COUNT_BYTE ^ 8'($urandom_range(1, 255));
      FLAW_TAIL:  b[12] = ffo_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255));
      FLAW_XOR:   b[11] = chk ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    add_byte(ffo_pkg::HDR_BYTE);
    for (int i = 0; i < int'(ffo_pkg::FRAME_LEN); i++) add_byte(b[i]);
    frames_sent++;
  endtask

  // mostly well-formed frames with random content, some broken ones, noise, fixes
  task automatic fill_random(input int n_words);
    int start, pick;
    logic [15:0] laser_dist;
    start = pending_words.size() + words_sent;
    while (pending_words.size() + words_sent - start < n_words) begin
      pick = $urandom_range(0, 99);
      laser_dist = ($urandom_range(0, 15) == 0)
                 ? ($urandom_range(0, 1) ? ffo_pkg::DIST_BAD : 16'd0)
                 : 16'($urandom());
      if (pick < 70)
        add_frame(16'($urandom()), 16'($urandom()), laser_dist, 8'($urandom()), FLAW_NONE);
      else if (pick < 82)
        add_frame(16'($urandom()), 16'($urandom()), laser_dist, 8'($urandom()),
                  flaw_e'($urandom_range(FLAW_COUNT, FLAW_FLAG)));
      else if (pick < 92)
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom()));
      else
        add_pose(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                 16'($urandom()));
    end
  endtask

  // wait for the block to drain, then let a full frame computation pass
  task automatic settle();
    while (pending_words.size() != 0 || s_axis_tvalid || odo_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ffo_pkg::CFG_FIXED_HEIGHT: fixed_height_r = val;
      ffo_pkg::CFG_CONF_FLOOR:   conf_floor_r = val[7:0];
      ffo_pkg::CFG_NEG_X:        neg_x_r = val[0];
      ffo_pkg::CFG_NEG_Y:        neg_y_r = val[0];
      ffo_pkg::CFG_MOUNT:        mount_r = val;
      ffo_pkg::CFG_START_YAW:    heading = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, one word per handshake
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    in_word_t w;
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 13);
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.data;
        s_axis_tuser <= w.pose;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (results_seen == 6 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      rx_gap = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted input word, checks each result word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    odo_result_t want;
    in_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_odometry(s_axis_tuser, s_axis_tdata);
      words_sent++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (odo_expected.size() == 0) begin
        $error("unexpected result word, data %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = odo_expected.pop_front();
        if (m_axis_tdata[47:0] !== want.map_x) begin
          $error("map_x_out: expected %h, got %h", want.map_x, m_axis_tdata[47:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[95:48] !== want.map_y) begin
          $error("map_y_out: expected %h, got %h", want.map_y, m_axis_tdata[95:48]);
          failed = 1'b1;
        end
        if (m_axis_tdata[111:96] !== want.height) begin
          $error("ground_height: expected %0d, got %0d", want.height, m_axis_tdata[111:96]);
          failed = 1'b1;
        end
        if (m_axis_tdata[127:112] !== want.yaw) begin
          $error("reported_yaw: expected %h, got %h", want.yaw, m_axis_tdata[127:112]);
          failed = 1'b1;
        end
        if (m_axis_tdata[143:128] !== want.flow_x) begin
          $error("raw_flow_x_out: expected %h, got %h", want.flow_x, m_axis_tdata[143:128]);
          failed = 1'b1;
        end
        if (m_axis_tdata[159:144] !== want.flow_y) begin
          $error("raw_flow_y_out: expected %h, got %h", want.flow_y, m_axis_tdata[159:144]);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frames, then random phases under several settings
  // ---------------------------------------------------------------------------
  initial begin
    fixed_height_r = '0;
    conf_floor_r = 8'd10;
    neg_x_r = 1'b0;
    neg_y_r = 1'b0;
    mount_r = '0;
    heading = '0;
    parse_phase = 0;
    acc_x = '0;
    acc_y = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings (laser height, confidence floor 10)
    add_frame(16'h0064, 16'hFF9C, 16'd1000, 8'd10, FLAW_NONE);    // confidence at floor
    add_frame(16'h0100, 16'h0100, 16'd1000, 8'd9, FLAW_NONE);     // confidence too low
    add_frame(16'h0100, 16'h0100, 16'd0, 8'd200, FLAW_NONE);      // no laser distance
    add_frame(16'h0100, 16'h0100, ffo_pkg::DIST_BAD, 8'd200, FLAW_NONE); // laser out of range
    add_frame(16'h7FFF, 16'h8000, 16'hFFFE, 8'hFF, FLAW_NONE);    // flow and height extremes
    add_frame(16'h8000, 16'h7FFF, 16'd1, 8'hFF, FLAW_NONE);
    add_frame(16'h00FE, 16'hFEFE, 16'h00FE, 8'hFE, FLAW_COUNT);   // header bytes inside
    add_frame(16'h0010, 16'h0020, 16'd500, 8'd50, FLAW_TAIL);
    add_frame(16'h0010, 16'h0020, 16'd500, 8'd50, FLAW_XOR);
    add_frame(16'h0010, 16'h0020, 16'd500, 8'd50, FLAW_FLAG);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_pose(48'h7FFF_FFFF_FFF0, 48'h8000_0000_0000, 16'hFFFF);   // near wrap
    add_frame(16'h7FFF, 16'h7FFF, 16'hFFFE, 8'hFF, FLAW_NONE);
    add_pose(48'h0, 48'h0, 16'h2000);                             // octant boundary
    add_frame(16'h1234, 16'hEDCC, 16'd3000, 8'd100, FLAW_NONE);
    fill_random(120);
    settle();

    cfg_write(ffo_pkg::CFG_FIXED_HEIGHT, 16'hFFFF);
    cfg_write(ffo_pkg::CFG_CONF_FLOOR, 16'h00FF);
    cfg_write(ffo_pkg::CFG_NEG_X, 16'h0001);
    cfg_write(ffo_pkg::CFG_NEG_Y, 16'h0001);
    cfg_write(ffo_pkg::CFG_MOUNT, 16'h4000);
    cfg_write(ffo_pkg::CFG_START_YAW, 16'hC000);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    fill_random(180);
    settle();

    cfg_write(ffo_pkg::CFG_FIXED_HEIGHT, 16'h0001);
    cfg_write(ffo_pkg::CFG_NEG_X, 16'h0000);
    cfg_write(ffo_pkg::CFG_MOUNT, 16'hFFFF);
    cfg_write(ffo_pkg::CFG_START_YAW, 16'h6000);
    fill_random(170);
    settle();

    // last stretch runs without idling on either side
    cfg_write(ffo_pkg::CFG_FIXED_HEIGHT, 16'h0000);
    cfg_write(ffo_pkg::CFG_CONF_FLOOR, 16'h0000);
    cfg_write(ffo_pkg::CFG_NEG_Y, 16'h0000);
    cfg_write(ffo_pkg::CFG_MOUNT, 16'h0000);
    cfg_write(ffo_pkg::CFG_START_YAW, 16'h0000);
    calm = 1'b1;
    fill_random(150);
    settle();

    $display("covered %0d words: %0d frames, %0d pose fixes, %0d result words",
             words_sent, frames_sent, poses_sent, results_seen);
    $display("register writes: %0d over four settings, one long output stall", cfg_writes);
    if (!failed) begin
      $display("flow_frame_odometry_test: PASS");
    end else begin
      $display("flow_frame_odometry_test: FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("flow_frame_odometry_test: FAIL");
    $finish;
  end

endmodule
